// ----- design/frasm_pkg.sv -----
// ----------------------------------------------------------------------------
// frasm_pkg
// Shared constants for the fragment reassembler: default sizes, stream
// widths, field positions and the result kind and item mode codes.
// ----------------------------------------------------------------------------
package frasm_pkg;

    // Default configuration of the reassembly buffer
    localparam int FRAG_DATA_DEF   = 240;
    localparam int STORE_BYTES_DEF = 1029;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 11;   // read_address and message_length

    // Stream widths (tdata padded to whole bytes)
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;

    // Input tdata field positions (lowest bit of each field)
    localparam int IN_MID_LSB   = 0;
    localparam int IN_FIDX_LSB  = 8;
    localparam int IN_FTOT_LSB  = 16;
    localparam int IN_FLEN_LSB  = 24;
    localparam int IN_POS_LSB   = 32;
    localparam int IN_PBYTE_LSB = 40;
    localparam int IN_RADDR_LSB = 48;

    // Idle mark of the current message id
    localparam logic [BYTE_W-1:0] IDLE_ID = 8'hFF;

    // Input item mode (carried in tuser)
    localparam logic MODE_FRAG = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Result kind (carried in tuser)
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

endpackage

// ----- design/fragment_reassembler.sv -----
// ----------------------------------------------------------------------------
// fragment_reassembler
// Byte-serial reassembly of fragmented messages into a byte buffer, with
// completion notices and buffer read-back.
// ----------------------------------------------------------------------------
// The block takes one item per cycle on the slave stream while no clearing
// pass runs and no waiting result stalls it, a rate set by the one buffer
// access (a write or a read) that each item needs in stage two. A result
// passes three stages before it is valid on the master side: stage one
// registers the item and the fragment offset (fragment_index * FRAG_DATA),
// stage two checks bounds, writes the payload byte into the buffer RAM,
// updates the message counters and issues buffer reads, and stage three is
// the output register, whose read data is the RAM's own read register. Only
// items with a result (a read or a completion) enter stage three, so a result
// waiting on the master side holds the stages behind it; once all three
// stages are full the slave side stalls until the result is taken. Bubbles
// collapse. After reset the buffer is zeroed by a clearing pass, one byte a
// cycle, during which no item is accepted.
// ----------------------------------------------------------------------------
module fragment_reassembler #(
    parameter int FRAG_DATA   = frasm_pkg::FRAG_DATA_DEF,
    parameter int STORE_BYTES = frasm_pkg::STORE_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Slave side
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: message_id[7:0], fragment_index[15:8], fragment_total[23:16],
    //        fragment_length[31:24], byte_position[39:32], payload_byte[47:40],
    //        read_address[58:48], zero fill[63:59]
    input  logic [frasm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: mode[0]
    input  logic                             i_s_tuser,
    // Master side
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: completed_id[7:0], message_length[18:8], read_byte[26:19],
    //        zero fill[31:27]
    output logic [frasm_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // tuser: result_kind[0]
    output logic                             o_m_tuser
);
    import frasm_pkg::*;

    localparam int AW    = $clog2(STORE_BYTES);
    localparam int SUM_W = $clog2(255 * FRAG_DATA + 256 + STORE_BYTES);
    localparam int RA_W  = ((AW > ADDR_W) ? AW : ADDR_W) + 1;

    // Unpack the input item
    logic [BYTE_W-1:0] in_mid, in_fidx, in_ftot, in_flen, in_pos, in_pbyte;
    logic [ADDR_W-1:0] in_raddr;

    assign in_mid   = i_s_tdata[IN_MID_LSB   +: BYTE_W];
    assign in_fidx  = i_s_tdata[IN_FIDX_LSB  +: BYTE_W];
    assign in_ftot  = i_s_tdata[IN_FTOT_LSB  +: BYTE_W];
    assign in_flen  = i_s_tdata[IN_FLEN_LSB  +: BYTE_W];
    assign in_pos   = i_s_tdata[IN_POS_LSB   +: BYTE_W];
    assign in_pbyte = i_s_tdata[IN_PBYTE_LSB +: BYTE_W];
    assign in_raddr = i_s_tdata[IN_RADDR_LSB +: ADDR_W];

    // Pipeline registers
    logic              r_s1_vld, r_s2_vld, r_s3_vld;
    logic              r_s2_mode;
    logic [BYTE_W-1:0] r_s2_mid, r_s2_ftot, r_s2_flen, r_s2_pos, r_s2_pbyte;
    logic [ADDR_W-1:0] r_s2_raddr;
    logic [SUM_W-1:0]  r_s2_off;
    logic              r_s3_kind, r_s3_oor;
    logic [BYTE_W-1:0] r_s3_id;
    logic [ADDR_W-1:0] r_s3_len;

    // Message state
    logic [BYTE_W-1:0] r_cur_id, r_exp_cnt, r_rcv_cnt;
    logic [BYTE_W-1:0] n_cur_id, n_exp_cnt, n_rcv_cnt;

    // Clearing pass
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // Stage enables: a stage moves when the one after it can take its item
    logic en3, en2, en1, s_acc, s2_fire;

    assign en3        = !r_s3_vld || i_m_tready;
    assign en2        = !r_s2_vld || en3;
    assign en1        = !r_s1_vld || en2;
    assign o_s_tready = en1 && !r_clearing;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign s2_fire    = r_s2_vld && en3;

    // Stage one: register the item and the fragment offset
    logic              r_s1_mode;
    logic [BYTE_W-1:0] r_s1_mid, r_s1_ftot, r_s1_flen, r_s1_pos, r_s1_pbyte;
    logic [ADDR_W-1:0] r_s1_raddr;
    logic [SUM_W-1:0]  r_s1_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en1) begin
            r_s1_vld <= s_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_mode  <= i_s_tuser;
            r_s1_mid   <= in_mid;
            r_s1_ftot  <= in_ftot;
            r_s1_flen  <= in_flen;
            r_s1_pos   <= in_pos;
            r_s1_pbyte <= in_pbyte;
            r_s1_raddr <= in_raddr;
            r_s1_off   <= SUM_W'(in_fidx) * SUM_W'(FRAG_DATA);
        end
    end

    // Advance stage one into stage two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en2) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_vld) begin
            r_s2_mode  <= r_s1_mode;
            r_s2_mid   <= r_s1_mid;
            r_s2_ftot  <= r_s1_ftot;
            r_s2_flen  <= r_s1_flen;
            r_s2_pos   <= r_s1_pos;
            r_s2_pbyte <= r_s1_pbyte;
            r_s2_raddr <= r_s1_raddr;
            r_s2_off   <= r_s1_off;
        end
    end

    // Stage two: bounds checks, counters and completion
    logic              is_frag, is_read, id_new, pos_bad, overrun, last;
    logic              wr_item, count, done, rd_in_range;
    logic [SUM_W-1:0]  end_sum;
    logic [BYTE_W-1:0] base_cnt, eff_exp, inc_cnt;
    logic [AW-1:0]     item_addr;

    assign is_frag     = (r_s2_mode == MODE_FRAG);
    assign is_read     = (r_s2_mode == MODE_READ);
    assign id_new      = (r_s2_mid != r_cur_id);
    assign pos_bad     = (r_s2_flen != '0) && (r_s2_pos >= r_s2_flen);
    assign end_sum     = r_s2_off + SUM_W'(r_s2_flen);
    assign overrun     = (end_sum > SUM_W'(STORE_BYTES));
    assign last        = (r_s2_flen == '0) ||
                         (({1'b0, r_s2_pos} + 9'd1) == {1'b0, r_s2_flen});
    assign wr_item     = s2_fire && is_frag && !pos_bad && !overrun && (r_s2_flen != '0);
    assign count       = is_frag && !pos_bad && !overrun && last;
    assign base_cnt    = id_new ? '0 : r_rcv_cnt;
    assign eff_exp     = id_new ? r_s2_ftot : r_exp_cnt;
    assign inc_cnt     = base_cnt + 8'd1;
    assign done        = count && (inc_cnt == eff_exp);
    assign item_addr   = AW'(r_s2_off + SUM_W'(r_s2_pos));
    assign rd_in_range = (RA_W'(r_s2_raddr) < RA_W'(STORE_BYTES));

    // Next message state for a fragment item leaving stage two
    always_comb begin
        n_cur_id  = r_cur_id;
        n_exp_cnt = r_exp_cnt;
        n_rcv_cnt = r_rcv_cnt;
        if (s2_fire && is_frag) begin
            if (id_new) begin
                n_cur_id  = r_s2_mid;
                n_exp_cnt = r_s2_ftot;
                n_rcv_cnt = '0;
            end
            if (count) begin
                n_rcv_cnt = inc_cnt;
            end
            if (done) begin
                n_cur_id = IDLE_ID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_id  <= IDLE_ID;
            r_exp_cnt <= '0;
            r_rcv_cnt <= '0;
        end else begin
            r_cur_id  <= n_cur_id;
            r_exp_cnt <= n_exp_cnt;
            r_rcv_cnt <= n_rcv_cnt;
        end
    end

    // Stage three: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en3) begin
            r_s3_vld <= r_s2_vld && (is_read || done);
        end
    end

    // A message that completes on its first counted fragment carries the item's id
    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_s3_kind <= is_read ? KIND_READ : KIND_DONE;
            r_s3_id   <= is_read ? '0 : r_s2_mid;
            r_s3_len  <= is_read ? '0 : ADDR_W'(end_sum);
            r_s3_oor  <= !rd_in_range;
        end
    end

    // Clearing pass after reset: zero the buffer one byte a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(STORE_BYTES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Buffer RAM
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;

    assign ram_we    = r_clearing || wr_item;
    assign ram_waddr = r_clearing ? r_clr_addr : item_addr;
    assign ram_wdata = r_clearing ? '0 : r_s2_pbyte;
    assign ram_re    = s2_fire && is_read && rd_in_range;

    frasm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (AW'(r_s2_raddr)),
        .o_rdata (ram_rdata)
    );

    // Drive the master side
    logic [BYTE_W-1:0] out_byte;

    assign out_byte   = (r_s3_kind == KIND_READ && !r_s3_oor) ? ram_rdata : '0;
    assign o_m_tvalid = r_s3_vld;
    assign o_m_tuser  = r_s3_kind;
    assign o_m_tdata  = {5'd0, out_byte, r_s3_len, r_s3_id};

    // Checks
    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s2_vld && !wr_item)
        else $error("item in flight during clearing pass");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire && is_frag && done |=> r_cur_id == IDLE_ID)
        else $error("current id not idle after completion");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_item |-> (RA_W'(item_addr) < RA_W'(STORE_BYTES)))
        else $error("buffer write beyond store");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire && is_frag && id_new && !count |=> r_rcv_cnt == '0)
        else $error("received count not cleared on new message");

endmodule

// ----- design/frasm_ram.sv -----
// ----------------------------------------------------------------------------
// frasm_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds while no read is issued.
// ----------------------------------------------------------------------------
module frasm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
